FILE: rtl/cfrr_pkg.sv
// ----------------------------------------------------------------------------
// cfrr_pkg: shared types and constants for the command frame responder
// Word layouts for both channels, command codes and the reply burst record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfrr_pkg;

	localparam logic [6:0] CMD_MASK = 7'b1111111;
	localparam logic [6:0] CMD_FREQ = 7'h01;
	localparam logic [6:0] CMD_FLEN = 7'h02;

	localparam int MAX_RESULTS = 9;
	localparam int REPLY_MAX   = 7;
	localparam int HDR_BYTES   = 5;

	localparam logic KIND_NOTICE = 1'b0;
	localparam logic KIND_REPLY  = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_CSUM = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       end_of_frame;
	} req_word_t;

	typedef struct packed {
		logic       result_kind;
		logic       status_code;
		logic [7:0] reply_byte;
		logic       last_result;
	} rsp_word_t;

	// one queued result, last flag is added on the way out
	typedef struct packed {
		logic       result_kind;
		logic       status_code;
		logic [7:0] reply_byte;
	} item_t;

	typedef struct packed {
		logic [3:0]                    count;
		item_t [MAX_RESULTS-1:0]       items;
	} burst_t;

endpackage

`default_nettype wire

FILE: rtl/command_frame_register_responder_unit.sv
// ----------------------------------------------------------------------------
// command_frame_register_responder_unit: byte-wise command frame responder
// Checks the frame checksum, runs get/set commands on two settings and
// streams the status notices and reply frame bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req): one request byte per word, with
//    end_of_frame set on the last byte of a frame.
//  - rsp channel (rsp_valid/rsp_ready/rsp): status notices and reply bytes,
//    last_result marks the final word a frame produces.
//  - Bytes inside a frame are taken one per cycle and produce nothing.
//  - The closing byte builds a burst of 0 to 9 words combinationally; the
//    burst register takes it, then the output register passes the first word
//    to rsp, and the rest follow one per cycle while rsp_ready is high.
//  - A new frame may stream in while a burst drains; only the next closing
//    byte is held off (req_ready low) until the current burst has fully left
//    the burst register.
//  - When the receiver stalls, the output register holds its word and the
//    burst waits; nothing is dropped.
//  - Reset clears frame state, both settings, the burst and the output
//    register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module command_frame_register_responder_unit (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       req_valid,
	output logic                      req_ready,
	input  wire cfrr_pkg::req_word_t  req,
	output logic                      rsp_valid,
	input  wire                       rsp_ready,
	output cfrr_pkg::rsp_word_t       rsp
);
	import cfrr_pkg::*;

	logic        take;
	burst_t      burst;
	item_t       list_q [MAX_RESULTS];
	logic [3:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        busy_q;
	logic        out_free;
	logic        emit;
	logic        load;
	rsp_word_t   rsp_q;
	logic        rsp_valid_q;

	// frame-closing bytes wait for the burst register to empty
	assign req_ready = !busy_q || !req.end_of_frame;
	assign take      = req_valid && req_ready;
	assign load      = take && req.end_of_frame && (burst.count != 4'd0);

	cfrr_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (req),
		.burst  (burst)
	);

	assign out_free = !rsp_valid_q || rsp_ready;
	assign emit     = busy_q && out_free;

	// burst register: list of pending results and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= burst.count;
			idx_q  <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q == cnt_q - 4'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				list_q[k] <= burst.items[k];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (out_free) begin
			rsp_valid_q <= emit;
			if (emit) begin
				rsp_q.result_kind <= list_q[idx_q].result_kind;
				rsp_q.status_code <= list_q[idx_q].status_code;
				rsp_q.reply_byte  <= list_q[idx_q].reply_byte;
				rsp_q.last_result <= (idx_q == cnt_q - 4'd1);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/cfrr_frame.sv
// ----------------------------------------------------------------------------
// cfrr_frame: request frame tracker
// Keeps header, running sum and held-back checksum bytes of the current frame,
// owns the frequency and frame length settings, and builds the result burst
// for the word that closes a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfrr_frame (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       take,
	input  wire cfrr_pkg::req_word_t  word,
	output cfrr_pkg::burst_t          burst
);
	import cfrr_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  hdr_q [HDR_BYTES];
	logic [15:0] sum_q;
	logic [7:0]  held_q [2];
	logic [15:0] freq_q;
	logic [7:0]  flen_q;

	logic [7:0]  hdr_n [HDR_BYTES];
	logic [15:0] sum_n;
	logic [7:0]  held0_n;
	logic [15:0] rx_sum;
	logic        csum_err;
	logic        rd;
	logic [6:0]  cmd;
	logic        known;
	logic [2:0]  rlen;
	logic [7:0]  r [5];
	logic [15:0] rsum;
	logic [7:0]  rep [REPLY_MAX];
	logic [3:0]  off;
	logic [3:0]  j;
	logic [3:0]  rlen4;
	logic        wr_freq;
	logic        wr_flen;

	always_comb begin
		for (int p = 0; p < HDR_BYTES; p++) begin
			hdr_n[p] = (pos_q == 3'(p)) ? word.frame_byte : hdr_q[p];
		end
		sum_n   = sum_q + {8'd0, held_q[0]};
		held0_n = held_q[1];
		rx_sum  = {held0_n, word.frame_byte};
		csum_err = (rx_sum != sum_n);

		rd   = hdr_n[1][7];
		cmd  = hdr_n[1][6:0] & CMD_MASK;
		r[0] = hdr_n[0];
		r[1] = hdr_n[1];
		r[2] = 8'd0;
		r[3] = 8'd0;
		r[4] = 8'd0;
		rlen = 3'd0;
		known = 1'b0;
		wr_freq = 1'b0;
		wr_flen = 1'b0;
		if (cmd == CMD_FREQ) begin
			known = 1'b1;
			if (rd) begin
				r[2] = 8'd2;
				r[3] = freq_q[15:8];
				r[4] = freq_q[7:0];
				rlen = 3'd5;
			end else begin
				wr_freq = 1'b1;
				rlen = 3'd3;
			end
		end else if (cmd == CMD_FLEN) begin
			known = 1'b1;
			if (rd) begin
				r[2] = 8'd1;
				r[3] = flen_q;
				rlen = 3'd4;
			end else begin
				wr_flen = 1'b1;
				rlen = 3'd3;
			end
		end

		// unused reply slots are zero, so a plain five-term sum works
		rsum = {8'd0, r[0]} + {8'd0, r[1]} + {8'd0, r[2]} + {8'd0, r[3]} + {8'd0, r[4]};
		rlen4 = {1'b0, rlen};
		for (int i = 0; i < REPLY_MAX; i++) begin
			if (i < 5 && 4'(i) < rlen4)          rep[i] = r[i % 5];
			else if (4'(i) == rlen4)            rep[i] = rsum[15:8];
			else if (4'(i) == rlen4 + 4'd1)     rep[i] = rsum[7:0];
			else                                rep[i] = 8'd0;
		end

		off = csum_err ? 4'd1 : 4'd0;
		burst.count = off + (known ? rlen4 + 4'd3 : 4'd0);
		for (int k = 0; k < MAX_RESULTS; k++) begin
			j = 4'(k) - off;
			burst.items[k] = '0;
			if (csum_err && k == 0) begin
				burst.items[k].result_kind = KIND_NOTICE;
				burst.items[k].status_code = STATUS_CSUM;
			end else if (known && j == 4'd0) begin
				burst.items[k].result_kind = KIND_NOTICE;
				burst.items[k].status_code = STATUS_OK;
			end else if (known && j >= 4'd1 && j <= rlen4 + 4'd2) begin
				burst.items[k].result_kind = KIND_REPLY;
				burst.items[k].status_code = STATUS_OK;
				burst.items[k].reply_byte  = rep[3'(j - 4'd1)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			held_q[0] <= '0;
			held_q[1] <= '0;
			freq_q    <= '0;
			flen_q    <= '0;
			for (int p = 0; p < HDR_BYTES; p++) begin
				hdr_q[p] <= '0;
			end
		end else if (take) begin
			if (word.end_of_frame) begin
				// frame closed: settings update, per-frame state clears
				if (wr_freq) freq_q <= {hdr_n[3], hdr_n[4]};
				if (wr_flen) flen_q <= hdr_n[3];
				pos_q     <= '0;
				sum_q     <= '0;
				held_q[0] <= '0;
				held_q[1] <= '0;
				for (int p = 0; p < HDR_BYTES; p++) begin
					hdr_q[p] <= '0;
				end
			end else begin
				pos_q     <= (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;
				sum_q     <= sum_n;
				held_q[0] <= held0_n;
				held_q[1] <= word.frame_byte;
				for (int p = 0; p < HDR_BYTES; p++) begin
					hdr_q[p] <= hdr_n[p];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for command_frame_register_responder_unit
// Streams request frames (directed corner frames, then random well-formed,
// truncated, padded and noise frames) through the request channel, predicts
// every status notice and reply byte, and checks each response word in order
// while both sides idle at random and the receiver stalls for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import cfrr_pkg::*;

	localparam int ITEMS        = 445;     // random request words
	localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
	localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
	localparam int DRAIN_CYCLES = 20;      // quiet time after the last reply

	// read/write flag in bit 7 of the command byte
	localparam logic RW_WRITE = 1'b0;
	localparam logic RW_READ  = 1'b1;

	// ------------------------------------------------------------------
	// Reply predictor: tracks frame state and both settings, and holds the
	// response words still owed by the block, oldest first.
	// ------------------------------------------------------------------
	class reply_predictor;
		bit [2:0]       pos;       // bytes seen, saturates at 7
		bit [4:0][7:0]  hdr;       // frame bytes 0..4
		bit [15:0]      acc;       // sum of bytes no longer held back
		bit [1:0][7:0]  held;      // last two bytes, [0] is the older
		bit [15:0]      freq;
		bit [7:0]       flen;
		rsp_word_t      owed_words[$];
		int             mismatches, checked, frames, csum_notices, sets, gets;

		function void clear_frame();
			pos  = '0;
			hdr  = '0;
			acc  = '0;
			held = '0;
		endfunction

		function void owe(logic kind, logic code, logic [7:0] data, logic fin);
			rsp_word_t w;
			w.result_kind = kind;
			w.status_code = code;
			w.reply_byte  = data;
			w.last_result = fin;
			owed_words.push_back(w);
		endfunction

		function void take_request(req_word_t w);
			bit [15:0]     rx, sum;
			bit [6:0]      cmd;
			bit            rd;
			bit [6:0][7:0] rb;
			int            rlen, i;
			acc     = acc + held[0];
			held[0] = held[1];
			held[1] = w.frame_byte;
			if (pos < 5)
				hdr[pos] = w.frame_byte;
			if (pos < 7)
				pos++;
			if (!w.end_of_frame)
				return;

			frames++;
			rx   = {held[0], held[1]};
			rd   = hdr[1][7];
			cmd  = hdr[1][6:0] & CMD_MASK;
			rb   = '0;
			rb[0] = hdr[0];
			rb[1] = hdr[1];
			rlen = 0;
			if (cmd == CMD_FREQ) begin
				if (rd == RW_READ) begin
					rb[2] = 8'd2;
					rb[3] = freq[15:8];
					rb[4] = freq[7:0];
					rlen  = 5;
					gets++;
				end else begin
					freq  = {hdr[3], hdr[4]};
					rb[2] = 8'd0;
					rlen  = 3;
					sets++;
				end
			end else if (cmd == CMD_FLEN) begin
				if (rd == RW_READ) begin
					rb[2] = 8'd1;
					rb[3] = flen;
					rlen  = 4;
					gets++;
				end else begin
					flen  = hdr[3];
					rb[2] = 8'd0;
					rlen  = 3;
					sets++;
				end
			end

			// checksum notice comes first; it is the last word only when
			// the command is unknown
			if (rx != acc) begin
				owe(KIND_NOTICE, STATUS_CSUM, 8'h00, rlen == 0);
				csum_notices++;
			end
			if (rlen > 0) begin
				sum = '0;
				for (i = 0; i < rlen; i++)
					sum = sum + rb[i];
				rb[rlen]     = sum[15:8];
				rb[rlen + 1] = sum[7:0];
				owe(KIND_NOTICE, STATUS_OK, 8'h00, 1'b0);
				for (i = 0; i < rlen + 2; i++)
					owe(KIND_REPLY, STATUS_OK, rb[i], i == rlen + 1);
			end
			clear_frame();
		endfunction

		function int owed();
			return owed_words.size();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 50)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_reply(rsp_word_t got);
			rsp_word_t want;
			if (owed_words.size() == 0) begin
				report_mismatch($sformatf("response word %h with none owed", got));
				return;
			end
			want = owed_words.pop_front();
			checked++;
			if (got.result_kind !== want.result_kind)
				report_mismatch($sformatf("word %0d result_kind %b, want %b",
					checked, got.result_kind, want.result_kind));
			if (got.status_code !== want.status_code)
				report_mismatch($sformatf("word %0d status_code %b, want %b",
					checked, got.status_code, want.status_code));
			if (got.reply_byte !== want.reply_byte)
				report_mismatch($sformatf("word %0d reply_byte %h, want %h",
					checked, got.reply_byte, want.reply_byte));
			if (got.last_result !== want.last_result)
				report_mismatch($sformatf("word %0d last_result %b, want %b",
					checked, got.last_result, want.last_result));
		endtask
	endclass

	// ------------------------------------------------------------------
	// Clock, reset and the block's ports; every input known from time 0
	// ------------------------------------------------------------------
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	int        tx_idle_pct = 34;   // sender idle chance per word, percent
	int        rx_idle_pct = 69;   // receiver idle chance per cycle, percent
	logic      hold_rx     = 1'b0; // forces rsp_ready low during the hold-off
	int        sent        = 0;
	int        cycle_count = 0;
	logic [7:0] frame_q[$];        // frame under construction

	reply_predictor model;

	command_frame_register_responder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Monitor: handshakes are sampled at the rising edge, where all inputs
	// have been stable since the falling edge and outputs still show their
	// pre-edge values. The request is noted before the response is checked;
	// a closing byte can only produce words from the next cycle on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				model.take_request(req);
			if (rsp_valid && rsp_ready)
				model.check_reply(rsp);
		end
	end

	// Receiver: one ready decision per cycle, at the falling edge
	always @(negedge clk) begin
		rsp_ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
	end

	// Long hold-off on the response side, counted here so the sender keeps
	// offering words; the burst register fills and the closing byte of the
	// next frame must be held off by req_ready.
	task automatic hold_receiver(int n);
		hold_rx <= 1'b1;
		repeat (n) @(negedge clk);
		hold_rx <= 1'b0;
	endtask

	// One request word. Entered at a falling edge; leaves at the falling
	// edge after acceptance with valid still high, so back-to-back words
	// keep valid up without a glitch.
	task send_word(logic [7:0] data, logic eof);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= {data, eof};
		@(posedge clk);
		while (req_ready !== 1'b1)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_word(frame_q[i], i == frame_q.size() - 1);
	endtask

	// Appends the big-endian additive sum; a bad one has one bit flipped
	function void append_checksum(bit good);
		bit [15:0] s;
		s = '0;
		foreach (frame_q[i])
			s = s + frame_q[i];
		if (!good)
			s = s ^ (16'h0001 << $urandom_range(15));
		frame_q.push_back(s[15:8]);
		frame_q.push_back(s[7:0]);
	endfunction

	// Data values lean toward the extremes now and then
	function logic [7:0] data_value();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// Mostly well-formed get/set frames with random content; the rest are
	// unknown commands, bad checksums, padded, truncated and noise frames.
	task build_random_frame();
		int         r, k, n;
		logic [6:0] cmd;
		logic       rd;
		frame_q.delete();
		r = $urandom_range(99);
		if (r < 8) begin
			n = $urandom_range(1, 9);
			repeat (n) frame_q.push_back(8'($urandom_range(255)));
			return;
		end
		frame_q.push_back(8'($urandom_range(255)));
		k = $urandom_range(99);
		if (k < 40)
			cmd = CMD_FREQ;
		else if (k < 80)
			cmd = CMD_FLEN;
		else
			cmd = 7'($urandom_range(127));
		rd = 1'($urandom_range(1));
		frame_q.push_back({rd, cmd});
		if (rd == RW_WRITE) begin
			frame_q.push_back(8'($urandom_range(255)));  // byte 2 is not used
			if (cmd == CMD_FREQ) begin
				frame_q.push_back(data_value());
				frame_q.push_back(data_value());
			end else begin
				frame_q.push_back(data_value());
			end
		end
		// long frame: extra bytes only feed the sum
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) frame_q.push_back(8'($urandom_range(255)));
		end
		append_checksum($urandom_range(99) < 85);
		// short frame: missing bytes read as zero
		if (r < 16) begin
			n = $urandom_range(1, frame_q.size() - 1);
			while (frame_q.size() > n)
				void'(frame_q.pop_back());
		end
	endtask

	// Watchdog on the cycle counter
	initial begin
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int target, span, phase;
		model = new;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed frames: set and get of both settings with extreme data,
		// a checksum mismatch on a known command, one-byte frames that match
		// and miss, and a short write whose data bytes are missing.
		frame_q = '{8'h00, {RW_WRITE, CMD_FREQ}, 8'h02, 8'hFF, 8'hFF};
		append_checksum(1'b1);
		send_frame();
		frame_q = '{8'hFF, {RW_READ, CMD_FREQ}};
		append_checksum(1'b1);
		send_frame();
		frame_q = '{8'h12, {RW_WRITE, CMD_FLEN}, 8'h01, 8'h80};
		append_checksum(1'b0);
		send_frame();
		frame_q = '{8'h34, {RW_READ, CMD_FLEN}};
		append_checksum(1'b1);
		send_frame();
		frame_q = '{8'h00};
		send_frame();
		frame_q = '{8'hFF};
		send_frame();
		frame_q = '{8'h55, {RW_WRITE, CMD_FLEN}};
		send_frame();

		// Random frames in three idle phases; the third starts with the
		// long receiver hold-off while the sender streams flat out.
		target = sent + ITEMS;
		span   = ITEMS / 3;
		phase  = 0;
		while (sent < target) begin
			if (phase == 0 && sent >= target - 2 * span) begin
				phase       = 1;
				tx_idle_pct = 69;
				rx_idle_pct = 34;
			end else if (phase == 1 && sent >= target - span) begin
				phase       = 2;
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				fork
					hold_receiver(HOLD_CYCLES);
				join_none
			end
			build_random_frame();
			send_frame();
		end
		req_valid <= 1'b0;

		while (model.owed() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request words in %0d frames over %0d cycles",
			sent, model.frames, cycle_count);
		$display("%0d response words checked: %0d sets, %0d gets, %0d checksum errors",
			model.checked, model.sets, model.gets, model.csum_notices);
		if (model.mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
